### hw/rtl/idle_busy_group_reroute_coordinator_top_macros.svh
// assertion macros for the coordinator rtl
// no dependencies
`ifndef IDLE_BUSY_GROUP_REROUTE_COORDINATOR_TOP_MACROS_SVH
`define IDLE_BUSY_GROUP_REROUTE_COORDINATOR_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ibgrc_pkg.sv
// constants and types for the group reroute coordinator
// no dependencies
`default_nettype none
package ibgrc_pkg;
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_IDLE     = 3'd1;
  localparam logic [2:0] CMD_CAPACITY = 3'd2;
  localparam logic [2:0] CMD_STATUS   = 3'd3;
  localparam logic [2:0] CMD_REJECT   = 3'd4;
  localparam logic [2:0] CMD_ACK      = 3'd5;
  localparam logic [2:0] CMD_CLOSE    = 3'd6;

  localparam logic [2:0] ST_UNKNOWN      = 3'd0;
  localparam logic [2:0] ST_WRITING      = 3'd1;
  localparam logic [2:0] ST_WRITING_MORE = 3'd2;
  localparam logic [2:0] ST_REJECTED     = 3'd3;
  localparam logic [2:0] ST_IDLE         = 3'd4;
  localparam logic [2:0] ST_PENDING      = 3'd5;
  localparam logic [2:0] ST_CAPACITY     = 3'd6;
  localparam logic [2:0] ST_CLOSED       = 3'd7;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REROUTE = 3'd1;
  localparam logic [2:0] ACT_INQUIRY = 3'd2;
  localparam logic [2:0] ACT_CLOSE   = 3'd3;
  localparam logic [2:0] ACT_MORE    = 3'd4;

  localparam logic [1:0] OUT_NOT_FOUND = 2'd0;
  localparam logic [1:0] OUT_FOUND     = 2'd1;
  localparam logic [1:0] OUT_FINISHED  = 2'd2;

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_WAIT   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam logic CFG_GROUP_COUNT = 1'b0;
  localparam logic CFG_COORD_GROUP = 1'b1;
endpackage
`default_nettype wire

### hw/rtl/idle_busy_group_reroute_coordinator_top.sv
// top level of the group reroute coordinator: sequencer around the status ram
// depends on ibgrc_pkg, ibgrc_ram and the assertion macro header
//
// channel    dir  fields (lsb first)
// s_axis     in   tdata: command[2:0] group_a[6:3] group_b[10:7] queue_nonempty[11]
//                        moved_writer[27:12], zero fill to 32
// m_axis     out  tdata: action[2:0] source_group[6:3] dest_group[10:7]
//                        writer_rank[26:11] search_outcome[28:27] all_done[29]
// cfg        in   cfg_we, cfg_index, cfg_data (group_count, coordinator_group)
//
// an event item reads the group_a status, then does up to two read-modify-writes (group_a, group_b)
// a search tick walks the status ram one entry a cycle, idle scan first, then busy scan
// after reset a clearing pass writes every status entry
// one item at a time; the result waits in an output register, s_tready low meanwhile
`default_nettype none
`include "idle_busy_group_reroute_coordinator_top_macros.svh"
module idle_busy_group_reroute_coordinator_top
  import ibgrc_pkg::*;
#(
  parameter int MAX_GROUPS = 16,
  parameter int RANK_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // command, group_a, group_b, queue_nonempty, moved_writer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // action, source_group, dest_group, writer_rank,
                                           // search_outcome, all_done
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);
  localparam int AW = $clog2(MAX_GROUPS);
  localparam int CW = $clog2(MAX_GROUPS + 1);

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RDA    = 4'd2;  // group_a status on rdata, a written
  localparam logic [3:0] S_RDB    = 4'd3;  // not entered by the sequencer
  localparam logic [3:0] S_FINB   = 4'd4;  // b data available
  localparam logic [3:0] S_ISCAN  = 4'd5;
  localparam logic [3:0] S_BSCAN  = 4'd6;
  localparam logic [3:0] S_WIDLE  = 4'd7;  // mark idle group pending
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_WAITA  = 4'd9;  // read latency for group_a
  localparam logic [3:0] S_WAITB  = 4'd10;

  logic [3:0] state;

  // configuration
  logic [4:0] group_count;
  logic [3:0] coordinator_group;
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= 5'd16;
      coordinator_group <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GROUP_COUNT: group_count <= cfg_data;
        CFG_COORD_GROUP: coordinator_group <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // group count clamped to the range 1 to MAX_GROUPS
  logic [CW-1:0] n_use;
  always_comb begin
    if (group_count == 5'd0) begin
      n_use = CW'(1);
    end else if (32'(group_count) > MAX_GROUPS) begin
      n_use = CW'(MAX_GROUPS);
    end else begin
      n_use = CW'(group_count);
    end
  end

  // idle and close masks in flip-flops, use mask decoded from the group count, one bit per group
  logic [MAX_GROUPS-1:0] idle_owed;
  logic [MAX_GROUPS-1:0] close_owed;
  logic [MAX_GROUPS-1:0] use_mask;
  always_comb begin
    for (int i = 0; i < MAX_GROUPS; i++) begin
      use_mask[i] = (CW'(i) < n_use);
    end
  end

  // latched item
  logic [2:0]  cmd;
  logic [3:0]  ga, gb;
  logic        qne;
  logic [15:0] rank;

  logic        a_ok, b_ok;
  assign a_ok = ({1'b0, ga} < 5'(n_use)) && (32'(ga) < MAX_GROUPS);
  assign b_ok = ({1'b0, gb} < 5'(n_use)) && (32'(gb) < MAX_GROUPS);

  // status ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2:0]    ram_wdata, ram_rdata;

  ibgrc_ram #(.WIDTH(3), .DEPTH(MAX_GROUPS)) u_status (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // scan and sequencing registers
  logic [AW-1:0] idle_ptr, busy_ptr;
  logic [AW-1:0] scan_ptr;          // entry whose read data arrives this cycle
  logic [CW-1:0] scan_left;         // entries still to be issued
  logic [CW-1:0] done_cnt;
  logic          scan_issued;
  logic [AW-1:0] idle_idx;
  logic          inquiry_pending;
  logic [1:0]    phase;
  logic [AW-1:0] clr_addr;

  // result register
  logic [2:0]  r_action;
  logic [3:0]  r_src, r_dst;
  logic [15:0] r_rank;
  logic [1:0]  r_outcome;

  // next pointer with wrap at the group count
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [CW-1:0] n);
    logic [CW:0] q;
    q = (CW+1)'(p) + (CW+1)'(1);
    if (q >= (CW+1)'(n)) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = AW'(q);
    end
  endfunction

  logic [AW-1:0] nxt_ptr;
  assign nxt_ptr = wrap_inc(scan_ptr, n_use);

  logic in_fire, out_fire;
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  logic any_idle_owed, any_close_owed_after;
  logic [MAX_GROUPS-1:0] close_owed_next;
  assign any_idle_owed = |(idle_owed & use_mask);

  // scan helpers
  logic [2:0]  wanted;
  logic        scan_hit, scan_fin;
  assign wanted   = (state == S_ISCAN) ? ST_IDLE : ST_WRITING;
  assign scan_hit = scan_issued && (ram_rdata == wanted);
  assign scan_fin = scan_issued && ((ram_rdata == ST_IDLE) || (ram_rdata == ST_CAPACITY));

  // last entry of a scan checked without a hit, and close broadcast on it
  logic scan_end, close_bcast;
  assign scan_end = ((state == S_ISCAN) || (state == S_BSCAN)) && scan_issued && !scan_hit &&
                    (scan_left == '0);
  assign close_bcast = scan_end && ((done_cnt + CW'(scan_fin)) == n_use) && !any_idle_owed;

  // ram port drive
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ST_UNKNOWN;
    ram_raddr = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_addr;
      end
      S_IDLE: ram_raddr = AW'(s_axis_tdata[6:3]);
      S_WAITA: ram_raddr = AW'(ga);
      S_WAITB: ram_raddr = AW'(gb);
      S_RDA: begin
        // status for group_a is on rdata
        ram_raddr = AW'(gb);
        ram_waddr = AW'(ga);
        if (a_ok) begin
          unique case (cmd)
            CMD_IDLE:     begin ram_we = 1'b1; ram_wdata = ST_IDLE; end
            CMD_CAPACITY: begin ram_we = 1'b1; ram_wdata = ST_CAPACITY; end
            CMD_STATUS:   begin ram_we = 1'b1; ram_wdata = qne ? ST_WRITING : ST_IDLE; end
            CMD_REJECT:   begin ram_we = (ram_rdata == ST_PENDING); ram_wdata = ST_REJECTED; end
            CMD_ACK:      begin ram_we = (ram_rdata == ST_PENDING); ram_wdata = ST_WRITING; end
            CMD_CLOSE:    begin ram_we = 1'b1; ram_wdata = ST_CLOSED; end
            default: ;
          endcase
        end
      end
      S_FINB: begin
        ram_waddr = AW'(gb);
        if (b_ok) begin
          if (cmd == CMD_REJECT) begin
            ram_we = (ram_rdata == ST_PENDING);
            ram_wdata = ST_IDLE;
          end else begin
            ram_we = 1'b1;
            ram_wdata = ST_WRITING_MORE;
          end
        end
      end
      S_ISCAN, S_BSCAN: begin
        ram_raddr = nxt_ptr;
        if (state == S_BSCAN && scan_hit) begin
          ram_we = 1'b1;
          ram_waddr = scan_ptr;
          ram_wdata = ST_PENDING;
        end
      end
      S_WIDLE: begin
        ram_we = 1'b1;
        ram_waddr = idle_idx;
        ram_wdata = ST_PENDING;
      end
      default: ;
    endcase
  end

  always_comb begin
    close_owed_next = close_owed;
    if (state == S_RDA && cmd == CMD_CLOSE && a_ok) begin
      close_owed_next[AW'(ga)] = 1'b0;
    end
    // coordinator's own close ack counts as received on the broadcast
    if (close_bcast && (32'(coordinator_group) < MAX_GROUPS)) begin
      close_owed_next[AW'(coordinator_group)] = 1'b0;
    end
  end
  assign any_close_owed_after = |(close_owed_next & use_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      idle_owed <= '1;
      close_owed <= '1;
      idle_ptr <= '0;
      busy_ptr <= '0;
      inquiry_pending <= 1'b1;
      phase <= PH_SEARCH;
      m_axis_tvalid <= 1'b0;
      scan_issued <= 1'b0;
    end else begin
      close_owed <= close_owed_next;
      if (out_fire) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == MAX_GROUPS - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd  <= s_axis_tdata[2:0];
            ga   <= s_axis_tdata[6:3];
            gb   <= s_axis_tdata[10:7];
            qne  <= s_axis_tdata[11];
            rank <= s_axis_tdata[27:12] & 16'((33'd1 << RANK_BITS) - 33'd1);
            r_action <= ACT_NONE;
            r_src <= '0;
            r_dst <= '0;
            r_rank <= '0;
            r_outcome <= OUT_NOT_FOUND;
            if (s_axis_tdata[2:0] == CMD_TICK) begin
              if (phase == PH_SEARCH) begin
                state <= S_ISCAN;
                scan_ptr <= idle_ptr;
                scan_left <= n_use;
                done_cnt <= '0;
                scan_issued <= 1'b0;
              end else begin
                state <= S_OUT;
              end
            end else begin
              state <= S_WAITA;
            end
          end
        end
        S_WAITA: state <= S_RDA;
        S_RDA: begin
          unique case (cmd)
            CMD_IDLE: begin
              if (a_ok) idle_owed[AW'(ga)] <= 1'b0;
              if (inquiry_pending) begin
                r_action <= ACT_INQUIRY;
                r_src <= ga;
                inquiry_pending <= 1'b0;
              end
            end
            CMD_CAPACITY: if (a_ok) idle_owed[AW'(ga)] <= 1'b0;
            CMD_ACK: begin
              r_action <= ACT_MORE;
              r_dst <= gb;
              r_rank <= rank;
              if (b_ok) idle_owed[AW'(gb)] <= 1'b1;
            end
            default: ;
          endcase
          if (cmd == CMD_REJECT || cmd == CMD_ACK) begin
            state <= S_WAITB;
          end else begin
            state <= S_OUT;
            if (phase == PH_WAIT && !any_close_owed_after) phase <= PH_DONE;
          end
        end
        S_WAITB: state <= S_FINB;
        S_FINB: begin
          state <= S_OUT;
          if (phase == PH_WAIT && !any_close_owed_after) phase <= PH_DONE;
        end
        S_ISCAN, S_BSCAN: begin
          // issue next read while checking the previous one
          if (scan_hit) begin
            scan_issued <= 1'b0;
          end else if (scan_left != '0) begin
            scan_ptr <= nxt_ptr;
            scan_left <= scan_left - CW'(1);
            scan_issued <= 1'b1;
          end else begin
            scan_issued <= 1'b0;
          end
          if (scan_hit && state == S_ISCAN) begin
            done_cnt <= '0;
          end else if (scan_fin) begin
            done_cnt <= done_cnt + CW'(1);
          end
          if (scan_hit) begin
            if (state == S_ISCAN) begin
              idle_ptr <= scan_ptr;
              idle_idx <= scan_ptr;
              state <= S_BSCAN;
              scan_ptr <= busy_ptr;
              scan_left <= n_use;
            end else begin
              busy_ptr <= scan_ptr;
              r_action <= ACT_REROUTE;
              r_src <= 4'(scan_ptr);
              r_dst <= 4'(idle_idx);
              r_outcome <= OUT_FOUND;
              state <= S_WIDLE;
            end
          end else if (scan_end) begin
            // last entry checked without a hit
            if (state == S_ISCAN) idle_ptr <= scan_ptr;
            else busy_ptr <= scan_ptr;
            if ((done_cnt + CW'(scan_fin)) == n_use) begin
              r_outcome <= OUT_FINISHED;
              if (!any_idle_owed) begin
                r_action <= ACT_CLOSE;
                phase <= PH_WAIT;
              end
            end
            state <= S_OUT;
          end
        end
        S_WIDLE: state <= S_OUT;
        S_OUT: begin
          // close ack check after a close broadcast
          if (phase == PH_WAIT && !any_close_owed_after) phase <= PH_DONE;
          // output register is empty here, items are only taken when it is
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic done_flag;
  assign done_flag = (phase == PH_DONE);
  logic done_q;
  always_ff @(posedge clk) begin
    if (state == S_OUT) done_q <= done_flag || (phase == PH_WAIT && !any_close_owed_after);
  end

  assign m_axis_tdata = {2'b00, done_q, r_outcome, r_rank, r_dst, r_src, r_action};

  `ASSERT_ALWAYS(a_ready_idle, clk, rst, !(s_axis_tready && state != S_IDLE), "ready outside idle")
  `ASSERT_NEXT(a_done_sticky, clk, rst, phase == PH_DONE, phase == PH_DONE, "done phase left")
  `ASSERT_NEXT(a_fire_leaves, clk, rst, in_fire, state != S_IDLE, "item accepted but idle")
endmodule
`default_nettype wire

### hw/rtl/ibgrc_ram.sv
// generic single-port-write, one-read synchronous ram with registered read
// no dependencies
`default_nettype none
module ibgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
